### design/tat_pkg.sv
// ----------------------------------------------------------------------------
// tat_pkg
// types, codes and constants shared by the tour adjacency table modules
// ----------------------------------------------------------------------------
package tat_pkg;

	localparam int unsigned MaxPoints = 1024;
	localparam int unsigned AddrW     = $clog2(MaxPoints);
	localparam int unsigned PtW       = AddrW + 1;
	localparam logic [PtW-1:0] NoPoint = PtW'(MaxPoints);

	typedef enum logic [2:0] {
		OP_CREATE    = 3'd0,
		OP_BREAK_AB  = 3'd1,
		OP_BREAK_NXT = 3'd2,
		OP_RELABEL   = 3'd3,
		OP_QUERY     = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SLOT  = 2'd1,
		ST_WALK_ERR = 2'd2,
		ST_NO_PREV  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [AddrW-1:0] point_a;
		logic [AddrW-1:0] point_b;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PtW-1:0]   next_point;
		logic [PtW-1:0]   prev_point;
		logic [AddrW-1:0] position;
		logic [PtW-1:0]   cycle_number;
		logic [PtW-1:0]   cycle_count;
		logic [PtW-1:0]   min_cycle_size;
	} out_item_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_DO_OP, S_RD_T, S_BRK_NXT,
		S_RL_INIT, S_W_START, S_W_RD, S_W_STEP, S_W_RD_NX, S_W_NX,
		S_SCAN, S_SCAN_CHK, S_QRY, S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_en;
		logic cap_in;
		logic rd_a;
		logic rd_b;
		logic rd_t;
		logic rd_cur;
		logic rd_nx;
		logic do_op;
		logic brk_nxt;
		logic rl_init;
		logic w_start;
		logic w_step;
		logic w_nx;
		logic w_done;
		logic scan_rd;
		logic scan_chk;
		logic qry;
		logic set_walk_err;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       clr_last;
		logic [2:0] opcode;
		logic       a_ok;
		logic       t_ok;
		logic       seq_fail;
		logic       nx_fail;
		logic       at_start;
		logic       scan_hit;
		logic       scan_end;
		logic       count_full;
	} sts_t;

endpackage

### design/tour_adjacency_table.sv
// ----------------------------------------------------------------------------
// tour_adjacency_table
// two-slot neighbour table for tour cycles with relabel and query
// ----------------------------------------------------------------------------
// every accepted transaction gives one result transaction. after reset the
// block sweeps its tables before taking a transaction. create and break a-b
// read a's entries, then b's, then write once; break a-next reads a's
// entries, then its next point's, and writes only when both are in range;
// query and unknown opcodes read only a's entries. relabel first sweeps the
// cycle table, then walks each cycle and scans for the next unlabelled
// point. configuration may be written only when no transaction is in
// flight.
module tour_adjacency_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tat_pkg::PtW-1:0]    cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tat_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output tat_pkg::out_item_t         out_data
);

	tat_pkg::cmd_t cmd;
	tat_pkg::sts_t sts;

	// sequencer
	tat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tables and walk registers
	tat_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

### design/tat_ctrl.sv
// ----------------------------------------------------------------------------
// tat_ctrl
// sequencer for table operations, relabel walk and result handshake
// ----------------------------------------------------------------------------
module tat_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  tat_pkg::sts_t   sts,
	output tat_pkg::cmd_t   cmd
);

	tat_pkg::state_t state_q, state_d;
	logic            relabel_pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tat_pkg::S_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			tat_pkg::S_CLEAR: begin
				cmd.clr_en = 1'b1;
				// clear pass during relabel returns to the walk, not to idle
				if (sts.clr_last)
					state_d = relabel_pending_q ? tat_pkg::S_W_START : tat_pkg::S_IDLE;
			end
			tat_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = tat_pkg::S_RD_A;
				end
			end
			tat_pkg::S_RD_A: begin
				cmd.rd_a = 1'b1;
				case (sts.opcode)
					tat_pkg::OP_CREATE, tat_pkg::OP_BREAK_AB: state_d = tat_pkg::S_RD_B;
					tat_pkg::OP_BREAK_NXT: state_d = tat_pkg::S_RD_T;
					tat_pkg::OP_RELABEL:   state_d = tat_pkg::S_RL_INIT;
					tat_pkg::OP_QUERY:     state_d = tat_pkg::S_QRY;
					default:               state_d = tat_pkg::S_OUT;
				endcase
			end
			tat_pkg::S_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = tat_pkg::S_DO_OP;
			end
			tat_pkg::S_DO_OP: begin
				cmd.do_op = 1'b1;
				state_d   = tat_pkg::S_OUT;
			end
			tat_pkg::S_RD_T: begin
				// a's entries are registered now: fetch next's entry
				cmd.rd_t = 1'b1;
				if (sts.a_ok && sts.t_ok) state_d = tat_pkg::S_BRK_NXT;
				else                      state_d = tat_pkg::S_OUT;
			end
			tat_pkg::S_BRK_NXT: begin
				cmd.brk_nxt = 1'b1;
				state_d     = tat_pkg::S_OUT;
			end
			tat_pkg::S_RL_INIT: begin
				cmd.rl_init = 1'b1;
				state_d     = tat_pkg::S_CLEAR;
			end
			tat_pkg::S_W_START: begin
				cmd.w_start = 1'b1;
				state_d     = tat_pkg::S_W_RD;
			end
			tat_pkg::S_W_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = tat_pkg::S_W_STEP;
			end
			tat_pkg::S_W_STEP: begin
				if (sts.seq_fail) begin
					cmd.set_walk_err = 1'b1;
					state_d          = tat_pkg::S_OUT;
				end else begin
					cmd.w_step = 1'b1;
					if (sts.nx_fail) begin
						cmd.set_walk_err = 1'b1;
						state_d          = tat_pkg::S_OUT;
					end else begin
						state_d = tat_pkg::S_W_RD_NX;
					end
				end
			end
			tat_pkg::S_W_RD_NX: begin
				cmd.rd_nx = 1'b1;
				state_d   = tat_pkg::S_W_NX;
			end
			tat_pkg::S_W_NX: begin
				cmd.w_nx = 1'b1;
				if (sts.at_start) begin
					cmd.w_done = 1'b1;
					state_d    = tat_pkg::S_SCAN;
				end else begin
					state_d = tat_pkg::S_W_RD;
				end
			end
			tat_pkg::S_SCAN: begin
				cmd.scan_rd = 1'b1;
				state_d     = tat_pkg::S_SCAN_CHK;
			end
			tat_pkg::S_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				if (sts.scan_hit) begin
					if (sts.count_full) begin
						cmd.set_walk_err = 1'b1;
						state_d          = tat_pkg::S_OUT;
					end else begin
						state_d = tat_pkg::S_W_START;
					end
				end else if (sts.scan_end) begin
					state_d = tat_pkg::S_OUT;
				end else begin
					state_d = tat_pkg::S_SCAN;
				end
			end
			tat_pkg::S_QRY: begin
				cmd.qry = 1'b1;
				state_d = tat_pkg::S_OUT;
			end
			tat_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = tat_pkg::S_IDLE;
			end
			default: state_d = tat_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          relabel_pending_q <= 1'b0;
		else if (cmd.rl_init) relabel_pending_q <= 1'b1;
		else if (cmd.w_start) relabel_pending_q <= 1'b0;
	end

endmodule

### design/tat_datapath.sv
// ----------------------------------------------------------------------------
// tat_datapath
// neighbour, next, position and cycle memories with walk registers
// ----------------------------------------------------------------------------
module tat_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tat_pkg::PtW-1:0]    cfg_wdata,
	input  tat_pkg::in_item_t          in_data,
	input  tat_pkg::cmd_t              cmd,
	output tat_pkg::sts_t              sts,
	output tat_pkg::out_item_t         out_data
);

	localparam int unsigned AW = tat_pkg::AddrW;
	localparam int unsigned PW = tat_pkg::PtW;

	logic [PW-1:0] slot1_mem [tat_pkg::MaxPoints];
	logic [PW-1:0] slot2_mem [tat_pkg::MaxPoints];
	logic [PW-1:0] next_mem  [tat_pkg::MaxPoints];
	logic [AW-1:0] pos_mem   [tat_pkg::MaxPoints];
	logic [PW-1:0] cyc_mem   [tat_pkg::MaxPoints];

	logic [PW-1:0] num_q;
	logic [PW-1:0] n_use;
	logic [2:0]    op_q;
	logic [AW-1:0] a_q, b_q;
	logic [AW:0]   clr_q;
	logic          clr_all_q;
	logic [PW-1:0] a1_q, a2_q, an_q, b1_q, b2_q;
	logic [PW-1:0] c1_q, c2_q, cn_q, ccyc_q;
	logic [AW-1:0] apos_q;
	logic [PW-1:0] acyc_q;
	logic [AW-1:0] cur_q, start_q, from_q;
	logic [PW-1:0] seq_q, found_q, small_q;
	logic [AW-1:0] scan_q;
	logic [1:0]    status_q;
	logic [PW-1:0] onx_q, opv_q, ocyc_q;
	logic [AW-1:0] opos_q;

	always_comb begin
		n_use = num_q;
		if (num_q > PW'(tat_pkg::MaxPoints)) n_use = PW'(tat_pkg::MaxPoints);
		if (num_q < PW'(2))                  n_use = PW'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     num_q <= PW'(tat_pkg::MaxPoints);
		else if (cfg_we) num_q <= cfg_wdata;
	end

	// clear counter: full reset clears cycle, slot and next stores, relabel clears cycle store only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			clr_all_q <= 1'b1;
		end else if (cmd.rl_init) begin
			clr_q     <= '0;
			clr_all_q <= 1'b0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	logic          a_ok, b_ok, t_ok;
	logic          take_a1, take_a2, take_b1, take_b2, cr_ok;
	logic [PW-1:0] bp, ap, tp;

	assign a_ok = {1'b0, a_q} < n_use;
	assign b_ok = {1'b0, b_q} < n_use;
	assign ap   = {1'b0, a_q};
	assign bp   = {1'b0, b_q};
	assign tp   = an_q;
	assign t_ok = an_q < n_use;

	always_comb begin
		// create: a's slot choice, then b's as seen after a's fill (a==b case)
		logic [PW-1:0] b1e, b2e;
		take_a1 = (a1_q == tat_pkg::NoPoint);
		take_a2 = !take_a1 && (a2_q == tat_pkg::NoPoint);
		b1e = (a_q == b_q && take_a1) ? bp : b1_q;
		b2e = (a_q == b_q && take_a2) ? bp : b2_q;
		take_b1 = (b1e == tat_pkg::NoPoint);
		take_b2 = !take_b1 && (b2e == tat_pkg::NoPoint);
		cr_ok = (take_a1 || take_a2) && (take_b1 || take_b2);
	end

	logic [PW-1:0] other_c;
	assign other_c = (c1_q == {1'b0, from_q}) ? c2_q : c1_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			cyc_mem[clr_q[AW-1:0]] <= tat_pkg::NoPoint;
			if (clr_all_q) begin
				slot1_mem[clr_q[AW-1:0]] <= tat_pkg::NoPoint;
				slot2_mem[clr_q[AW-1:0]] <= tat_pkg::NoPoint;
				next_mem[clr_q[AW-1:0]]  <= tat_pkg::NoPoint;
			end
		end
		if (cmd.cap_in) begin
			op_q <= in_data.opcode;
			a_q  <= in_data.point_a;
			b_q  <= in_data.point_b;
		end
		if (cmd.rd_a) begin
			a1_q   <= slot1_mem[a_q];
			a2_q   <= slot2_mem[a_q];
			an_q   <= next_mem[a_q];
			apos_q <= pos_mem[a_q];
			acyc_q <= cyc_mem[a_q];
		end
		if (cmd.rd_b) begin
			b1_q <= slot1_mem[b_q];
			b2_q <= slot2_mem[b_q];
		end
		if (cmd.rd_t) begin
			b1_q <= slot1_mem[an_q[AW-1:0]];
			b2_q <= slot2_mem[an_q[AW-1:0]];
		end
		if (cmd.do_op && a_ok && b_ok) begin
			if (op_q == tat_pkg::OP_CREATE) begin
				if (cr_ok) begin
					if (a_q == b_q) begin
						slot1_mem[a_q] <= bp;
						slot2_mem[a_q] <= bp;
					end else begin
						if (take_a1) slot1_mem[a_q] <= bp; else slot2_mem[a_q] <= bp;
						if (take_b1) slot1_mem[b_q] <= ap; else slot2_mem[b_q] <= ap;
					end
				end
			end else begin
				// break a-b; with a==b the second free sees the first's result
				if (a_q == b_q) begin
					if (a1_q == bp) begin
						slot1_mem[a_q] <= tat_pkg::NoPoint;
						if (a2_q == bp) slot2_mem[a_q] <= tat_pkg::NoPoint;
					end else if (a2_q == bp) begin
						slot2_mem[a_q] <= tat_pkg::NoPoint;
					end
				end else begin
					if (a1_q == bp)      slot1_mem[a_q] <= tat_pkg::NoPoint;
					else if (a2_q == bp) slot2_mem[a_q] <= tat_pkg::NoPoint;
					if (b1_q == ap)      slot1_mem[b_q] <= tat_pkg::NoPoint;
					else if (b2_q == ap) slot2_mem[b_q] <= tat_pkg::NoPoint;
				end
			end
		end
		if (cmd.brk_nxt) begin
			if (tp == ap) begin
				if (a1_q == tp) begin
					slot1_mem[a_q] <= tat_pkg::NoPoint;
					if (a2_q == ap) slot2_mem[a_q] <= tat_pkg::NoPoint;
				end else if (a2_q == tp) begin
					slot2_mem[a_q] <= tat_pkg::NoPoint;
				end
			end else begin
				if (a1_q == tp)      slot1_mem[a_q] <= tat_pkg::NoPoint;
				else if (a2_q == tp) slot2_mem[a_q] <= tat_pkg::NoPoint;
				if (b1_q == ap)      slot1_mem[tp[AW-1:0]] <= tat_pkg::NoPoint;
				else if (b2_q == ap) slot2_mem[tp[AW-1:0]] <= tat_pkg::NoPoint;
			end
		end
		if (cmd.rd_cur) begin
			c1_q <= slot1_mem[cur_q];
			// the start point leaves by its first slot
			cn_q <= (seq_q == '0) ? slot1_mem[cur_q] : next_mem[cur_q];
		end
		if (cmd.w_step) begin
			pos_mem[cur_q] <= seq_q[AW-1:0];
			if (seq_q == '0) next_mem[cur_q] <= cn_q;
		end
		if (cmd.rd_nx) begin
			c1_q <= slot1_mem[cn_q[AW-1:0]];
			c2_q <= slot2_mem[cn_q[AW-1:0]];
		end
		if (cmd.w_nx) begin
			next_mem[cn_q[AW-1:0]] <= other_c;
			cyc_mem[cn_q[AW-1:0]]  <= found_q;
		end
		if (cmd.scan_rd) ccyc_q <= cyc_mem[scan_q];
	end

	// walk control registers
	logic scan_hit;
	assign scan_hit = (ccyc_q == tat_pkg::NoPoint);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= '0;
			small_q  <= tat_pkg::NoPoint;
			status_q <= tat_pkg::ST_OK;
			cur_q    <= '0;
			start_q  <= '0;
			from_q   <= '0;
			seq_q    <= '0;
			scan_q   <= '0;
		end else begin
			if (cmd.cap_in) status_q <= tat_pkg::ST_OK;
			if (cmd.do_op && a_ok && b_ok && op_q == tat_pkg::OP_CREATE && !cr_ok)
				status_q <= tat_pkg::ST_NO_SLOT;
			if (cmd.rl_init) begin
				found_q <= '0;
				small_q <= tat_pkg::NoPoint;
				start_q <= '0;
			end
			if (cmd.w_start) begin
				cur_q <= start_q;
				seq_q <= '0;
			end
			if (cmd.w_step) begin
				seq_q  <= seq_q + 1'b1;
				from_q <= cur_q;
			end
			if (cmd.w_nx) cur_q <= cn_q[AW-1:0];
			if (cmd.w_done) begin
				if (seq_q < small_q) small_q <= seq_q;
				found_q <= found_q + 1'b1;
				scan_q  <= '0;
			end
			if (cmd.scan_chk) begin
				if (scan_hit) start_q <= scan_q;
				else          scan_q  <= scan_q + 1'b1;
			end
			if (cmd.set_walk_err) status_q <= tat_pkg::ST_WALK_ERR;
			if (cmd.qry && a_ok && !(a1_q == an_q || a2_q == an_q))
				status_q <= tat_pkg::ST_NO_PREV;
		end
	end

	// query result
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			onx_q  <= tat_pkg::NoPoint;
			opv_q  <= tat_pkg::NoPoint;
			ocyc_q <= tat_pkg::NoPoint;
			opos_q <= '0;
		end
		if (cmd.qry && a_ok) begin
			onx_q  <= an_q;
			opv_q  <= (a1_q == an_q) ? a2_q : ((a2_q == an_q) ? a1_q : tat_pkg::NoPoint);
			ocyc_q <= acyc_q;
			opos_q <= apos_q;
		end
	end

	assign sts.clr_last   = (clr_q == (AW+1)'(tat_pkg::MaxPoints - 1));
	assign sts.opcode     = op_q;
	assign sts.a_ok       = a_ok;
	assign sts.t_ok       = t_ok;
	assign sts.seq_fail   = (seq_q >= n_use);
	assign sts.nx_fail    = (cn_q >= n_use);
	assign sts.at_start   = (cn_q[AW-1:0] == start_q);
	assign sts.scan_hit   = scan_hit;
	assign sts.scan_end   = ({1'b0, scan_q} == n_use - 1'b1);
	assign sts.count_full = (found_q >= n_use);

	assign out_data.status         = status_q;
	assign out_data.next_point     = onx_q;
	assign out_data.prev_point     = opv_q;
	assign out_data.position       = opos_q;
	assign out_data.cycle_number   = ocyc_q;
	assign out_data.cycle_count    = found_q;
	assign out_data.min_cycle_size = small_q;

endmodule

### design/tat_checker.sv
// ----------------------------------------------------------------------------
// tat_checker
// port-level checks of the transaction sequencing
// ----------------------------------------------------------------------------
module tat_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tat_pkg::out_item_t  out_data
);

	// no new transaction while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");

	// a result never appears in the cycle after acceptance
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(out_data))
		else $error("result dropped");

	// a missing previous neighbour is reported with no previous point
	a_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == tat_pkg::ST_NO_PREV) |->
		out_data.prev_point == tat_pkg::NoPoint) else $error("bad prev");

endmodule

bind tour_adjacency_table tat_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### sim/tb_tour_adjacency_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tour_adjacency_table
// self-checking bench: a stimulus table, then random episodes that wire up
// whole cycles, relabel, query and tear down again, each checked against the
// row's own expectation or an in-bench model of the neighbour tables
// ----------------------------------------------------------------------------
module tb_tour_adjacency_table;
	import tat_pkg::*;

	localparam logic [2:0] OP_NOP   = 3'd7;
	localparam int         WdogLim  = 200000;
	localparam int         HoldLen  = 400;
	localparam out_item_t  IDLE_RES = '{ST_OK, NoPoint, NoPoint, '0, NoPoint, '0, NoPoint};

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [PtW-1:0] cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	tour_adjacency_table DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// shadow copy of the block's tables
	logic [PtW-1:0]   sh_np;
	logic [PtW-1:0]   sh_s1 [MaxPoints];
	logic [PtW-1:0]   sh_s2 [MaxPoints];
	logic [PtW-1:0]   sh_nxt [MaxPoints];
	logic [AddrW-1:0] sh_pos [MaxPoints];
	logic             sh_pos_ok [MaxPoints];
	logic [PtW-1:0]   sh_cyc [MaxPoints];
	logic [PtW-1:0]   sh_found;
	logic [PtW-1:0]   sh_smallest;

	out_item_t pending_results[$];
	int        errors;
	int        items_sent;
	bit        no_idle;
	bit        hold_req;
	int        hold_left;

	typedef struct {
		logic [2:0]       op;
		logic [AddrW-1:0] a;
		logic [AddrW-1:0] b;
		bit               typed;
		out_item_t        want;
	} step_t;

	step_t plan[$];

	function automatic int used_n();
		int n;
		n = sh_np;
		if (n > MaxPoints) n = MaxPoints;
		if (n < 2) n = 2;
		return n;
	endfunction

	// walk one cycle from start; size, or 0 on a broken walk
	function automatic int walk_one(int start, int id, int n);
		int cur, seq, from, nx;
		cur = start;
		seq = 0;
		sh_nxt[cur] = sh_s1[cur];
		do begin
			from = cur;
			if (seq >= n) return 0;
			sh_pos[cur] = AddrW'(seq);
			sh_pos_ok[cur] = 1'b1;
			seq++;
			nx = sh_nxt[cur];
			if (nx >= n) return 0;
			cur = nx;
			sh_nxt[cur] = (sh_s1[cur] == from) ? sh_s2[cur] : sh_s1[cur];
			sh_cyc[cur] = PtW'(id);
		end while (cur != start);
		return seq;
	endfunction

	function automatic status_t relabel_all(int n);
		int start, size;
		for (int i = 0; i < MaxPoints; i++) sh_cyc[i] = NoPoint;
		sh_found = '0;
		sh_smallest = NoPoint;
		start = 0;
		while (start < n) begin
			size = walk_one(start, sh_found, n);
			if (size == 0) return ST_WALK_ERR;
			if (size < sh_smallest) sh_smallest = PtW'(size);
			sh_found++;
			start = NoPoint;
			for (int i = 0; i < n; i++) begin
				if (sh_cyc[i] == NoPoint) begin
					start = i;
					break;
				end
			end
			if (sh_found >= n && start != NoPoint) return ST_WALK_ERR;
		end
		return ST_OK;
	endfunction

	function automatic void unlink(int p, int v);
		if (sh_s1[p] == v) sh_s1[p] = NoPoint;
		else if (sh_s2[p] == v) sh_s2[p] = NoPoint;
	endfunction

	function automatic bit grab(int p, int v);
		if (sh_s1[p] == NoPoint) begin
			sh_s1[p] = PtW'(v);
			return 1'b1;
		end
		if (sh_s2[p] == NoPoint) begin
			sh_s2[p] = PtW'(v);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// append one row to the stimulus table
	function automatic void add_row(logic [2:0] op, logic [AddrW-1:0] a,
		logic [AddrW-1:0] b, bit typed, out_item_t want);
		step_t s;
		s.op = op;
		s.a = a;
		s.b = b;
		s.typed = typed;
		s.want = want;
		plan.insert(plan.size(), s);
	endfunction

	// expected result of one transaction, with the shadow tables updated
	function automatic out_item_t table_step(in_item_t it);
		out_item_t r;
		int n, a, b, t;
		logic [PtW-1:0] a1, a2, b1, b2;
		n = used_n();
		a = it.point_a;
		b = it.point_b;
		r = IDLE_RES;
		case (it.opcode)
			OP_CREATE: begin
				if (a < n && b < n) begin
					a1 = sh_s1[a]; a2 = sh_s2[a]; b1 = sh_s1[b]; b2 = sh_s2[b];
					if (!grab(a, b) || !grab(b, a)) begin
						sh_s1[a] = a1; sh_s2[a] = a2; sh_s1[b] = b1; sh_s2[b] = b2;
						r.status = ST_NO_SLOT;
					end
				end
			end
			OP_BREAK_AB: begin
				if (a < n && b < n) begin
					unlink(a, b);
					unlink(b, a);
				end
			end
			OP_BREAK_NXT: begin
				if (a < n) begin
					t = sh_nxt[a];
					if (t < n) begin
						unlink(a, t);
						unlink(t, a);
					end
				end
			end
			OP_RELABEL: r.status = relabel_all(n);
			OP_QUERY: begin
				if (a < n) begin
					r.next_point = sh_nxt[a];
					if (sh_s1[a] == r.next_point) r.prev_point = sh_s2[a];
					else if (sh_s2[a] == r.next_point) r.prev_point = sh_s1[a];
					else r.status = ST_NO_PREV;
					r.position = sh_pos[a];
					r.cycle_number = sh_cyc[a];
				end
			end
			default: ;
		endcase
		r.cycle_count = sh_found;
		r.min_cycle_size = sh_smallest;
		return r;
	endfunction

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HoldLen;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 35);
			end
		end
	end

	// result checker, field by field against the oldest expectation
	always @(posedge clk) begin
		out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected: %p", out_data);
				errors++;
			end else begin
				w = pending_results.pop_front();
				if (out_data.status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, out_data.status);
					errors++;
				end
				if (out_data.next_point !== w.next_point) begin
					$error("next_point: expected %0d, got %0d", w.next_point,
						out_data.next_point);
					errors++;
				end
				if (out_data.prev_point !== w.prev_point) begin
					$error("prev_point: expected %0d, got %0d", w.prev_point,
						out_data.prev_point);
					errors++;
				end
				if (out_data.position !== w.position) begin
					$error("position: expected %0d, got %0d", w.position, out_data.position);
					errors++;
				end
				if (out_data.cycle_number !== w.cycle_number) begin
					$error("cycle_number: expected %0d, got %0d", w.cycle_number,
						out_data.cycle_number);
					errors++;
				end
				if (out_data.cycle_count !== w.cycle_count) begin
					$error("cycle_count: expected %0d, got %0d", w.cycle_count,
						out_data.cycle_count);
					errors++;
				end
				if (out_data.min_cycle_size !== w.min_cycle_size) begin
					$error("min_cycle_size: expected %0d, got %0d", w.min_cycle_size,
						out_data.min_cycle_size);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles in a row with no transaction on either side
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= WdogLim) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// configuration write, only ever called while no transaction is in flight
	task automatic set_points(logic [PtW-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_np = v;
	endtask

	// offer one transaction and record its expected result once taken
	task automatic send(in_item_t it, bit typed, out_item_t want);
		out_item_t r;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		r = table_step(it);
		pending_results.insert(pending_results.size(), typed ? want : r);
		items_sent++;
		if (!no_idle && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic put(logic [2:0] op, int a, int b);
		in_item_t it;
		it.opcode = op;
		it.point_a = AddrW'(a);
		it.point_b = AddrW'(b);
		send(it, 1'b0, IDLE_RES);
	endtask

	function automatic int pick_pt(int n);
		if ($urandom_range(0, 9) != 0) return $urandom_range(0, n - 1);
		return $urandom_range(0, MaxPoints - 1);
	endfunction

	// random transaction; never queries an in-range point with no position yet
	task automatic noise(int n);
		logic [2:0] op;
		int a;
		op = 3'($urandom_range(0, 7));
		a = pick_pt(n);
		if (op == OP_QUERY && a < n && !sh_pos_ok[a]) op = OP_CREATE;
		put(op, a, pick_pt(n));
	endtask

	// wait for the block to drain before touching the register
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// wire the points into random cycles, relabel, query, then tear down
	task automatic episode(int n, int max_cyc);
		int perm[$];
		int k, len, left, q, j;
		for (int i = 0; i < n; i++) perm.insert(perm.size(), i);
		perm.shuffle();
		k = 0;
		left = max_cyc;
		while (k < n) begin
			len = (left <= 1) ? n - k : $urandom_range(1, n - k);
			left--;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < 12) noise(n);
				put(OP_CREATE, perm[k + i], perm[k + ((i + 1) % len)]);
			end
			k += len;
		end
		put(OP_RELABEL, 0, 0);
		for (int i = 0; i < ((n < 12) ? n : 12); i++) begin
			q = $urandom_range(0, n - 1);
			if (sh_pos_ok[q]) put(OP_QUERY, q, $urandom_range(0, MaxPoints - 1));
			else noise(n);
		end
		if ($urandom_range(0, 1)) begin
			q = $urandom_range(0, n - 1);
			put(OP_BREAK_NXT, q, 0);
			if (sh_pos_ok[q]) put(OP_QUERY, q, 0);
			put(OP_RELABEL, 0, 0);
		end
		// empty each point's slots, with at most four breaks per point
		for (int p = 0; p < n; p++) begin
			j = 0;
			while ((sh_s1[p] != NoPoint || sh_s2[p] != NoPoint) && j < 4) begin
				if ($urandom_range(0, 99) < 10) noise(n);
				if (sh_s1[p] != NoPoint) put(OP_BREAK_AB, p, sh_s1[p]);
				else put(OP_BREAK_AB, p, sh_s2[p]);
				j++;
			end
		end
	endtask

	// main sequence
	initial begin
		int pts[7];
		int n, budget;
		errors = 0;
		items_sent = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		sh_np = MaxPoints;
		for (int i = 0; i < MaxPoints; i++) begin
			sh_s1[i] = NoPoint;
			sh_s2[i] = NoPoint;
			sh_nxt[i] = NoPoint;
			sh_pos[i] = '0;
			sh_pos_ok[i] = 1'b0;
			sh_cyc[i] = NoPoint;
		end
		sh_found = '0;
		sh_smallest = NoPoint;

		// directed table on four points
		add_row(OP_NOP, 10'd1023, 10'd1023, 1'b1, IDLE_RES);
		add_row(OP_QUERY, 10'd1023, 10'd0, 1'b1, IDLE_RES);
		add_row(OP_CREATE, 10'd0, 10'd1023, 1'b1, IDLE_RES);
		add_row(OP_BREAK_AB, 10'd1023, 10'd0, 1'b1, IDLE_RES);
		add_row(OP_BREAK_NXT, 10'd1023, 10'd0, 1'b1, IDLE_RES);
		// empty table: the walk dies on the first empty slot
		add_row(OP_RELABEL, 10'd0, 10'd0, 1'b1,
			'{ST_WALK_ERR, NoPoint, NoPoint, '0, NoPoint, '0, NoPoint});
		add_row(OP_QUERY, 10'd0, 10'd0, 1'b0, IDLE_RES);
		add_row(OP_CREATE, 10'd0, 10'd1, 1'b0, IDLE_RES);
		add_row(OP_CREATE, 10'd1, 10'd2, 1'b0, IDLE_RES);
		add_row(OP_CREATE, 10'd2, 10'd3, 1'b0, IDLE_RES);
		add_row(OP_CREATE, 10'd3, 10'd0, 1'b0, IDLE_RES);
		// point 0 is full, so no slot
		add_row(OP_CREATE, 10'd0, 10'd2, 1'b1,
			'{ST_NO_SLOT, NoPoint, NoPoint, '0, NoPoint, '0, NoPoint});
		add_row(OP_RELABEL, 10'd0, 10'd0, 1'b0, IDLE_RES);
		for (int i = 0; i < 4; i++)
			add_row(OP_QUERY, AddrW'(i), 10'd0, 1'b0, IDLE_RES);
		add_row(OP_BREAK_NXT, 10'd0, 10'd0, 1'b0, IDLE_RES);
		add_row(OP_BREAK_AB, 10'd2, 10'd3, 1'b0, IDLE_RES);
		add_row(OP_BREAK_AB, 10'd1, 10'd3, 1'b0, IDLE_RES);
		add_row(OP_CREATE, 10'd1, 10'd1, 1'b0, IDLE_RES);
		add_row(OP_CREATE, 10'd0, 10'd3, 1'b0, IDLE_RES);
		add_row(OP_QUERY, 10'd1, 10'd0, 1'b0, IDLE_RES);
		add_row(OP_QUERY, 10'd0, 10'd0, 1'b0, IDLE_RES);
		add_row(OP_RELABEL, 10'd0, 10'd0, 1'b0, IDLE_RES);
		add_row(OP_QUERY, 10'd3, 10'd0, 1'b0, IDLE_RES);

		@(posedge arst_n);
		set_points(PtW'(4));
		foreach (plan[i]) begin
			in_item_t it;
			it.opcode = plan[i].op;
			it.point_a = plan[i].a;
			it.point_b = plan[i].b;
			send(it, plan[i].typed, plan[i].want);
		end
		drain();

		// register settings per phase: the floor, raised-to-two, capped at
		// the table size, full size and a few in between
		pts = '{2, 0, 7, 16, 40, 2047, 1024};
		foreach (pts[ph]) begin
			set_points(PtW'(pts[ph]));
			n = used_n();
			no_idle = (ph == 4);
			if (ph == 3) hold_req = 1'b1;
			budget = items_sent + ((n >= MaxPoints) ? 90 : 130);
			while (items_sent < budget) begin
				if (n >= MaxPoints) begin
					// too big to wire fully: sparse edges and failing walks
					repeat (20) noise(n);
					put(OP_CREATE, $urandom_range(0, 3), $urandom_range(0, 3));
					put(OP_RELABEL, 0, 0);
				end else begin
					episode(n, (n > 16) ? 4 : n);
					repeat ($urandom_range(0, 8)) noise(n);
				end
			end
			// sender holds back until everything has come out
			drain();
		end
		no_idle = 1'b0;

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### sim.f
design/tat_pkg.sv
design/tat_ctrl.sv
design/tat_datapath.sv
design/tour_adjacency_table.sv
design/tat_checker.sv
sim/tb_tour_adjacency_table.sv
